### rtl/core/mep_pkg.sv
package mep_pkg;

  localparam int unsigned FRAC_BITS    = 28;
  localparam int unsigned PALETTE_SIZE = 8;
  localparam int unsigned PAL_IDX_W    = $clog2(PALETTE_SIZE);

  localparam int unsigned IDX_W    = 10;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned STEP_W   = 31;
  localparam int unsigned LIMIT_W  = 16;
  localparam int unsigned ESC_W    = 7;
  localparam int unsigned RGB_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned Z_W      = 37;
  localparam int unsigned SUM_W    = 43;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [ESC_W-1:0] ESC_MAX = ESC_W'(64);
  localparam logic [Z_W-1:0]   Z_BOUND = Z_W'(8) << FRAC_BITS;

  localparam logic [COORD_W-1:0] ORIGIN_REAL_RST = 32'hE000_0000;
  localparam logic [STEP_W-1:0]  STEP_REAL_RST   = 31'd786432;
  localparam logic [COORD_W-1:0] ORIGIN_IMAG_RST = 32'hF000_0000;
  localparam logic [STEP_W-1:0]  STEP_IMAG_RST   = 31'd786432;
  localparam logic [LIMIT_W-1:0] LIMIT_RST       = 16'd256;
  localparam logic [ESC_W-1:0]   ESC_RST         = 7'd16;

  localparam logic [RGB_W-1:0] PALETTE [PALETTE_SIZE] = '{
    24'hA0B965, 24'h908F84, 24'hBF3C43, 24'h9D8E70,
    24'hC9BE91, 24'hA0B965, 24'h908F84, 24'hBF3C43
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_STEP_REAL   = 3'd1,
    REG_ORIGIN_IMAG = 3'd2,
    REG_STEP_IMAG   = 3'd3,
    REG_ITER_LIMIT  = 3'd4,
    REG_ESC_SQUARE  = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MCR,
    ST_MCI,
    ST_INIT,
    ST_RI,
    ST_UPD,
    ST_SQR,
    ST_SQI,
    ST_FIN
  } state_e;

  // The offset is never negative, so only the upper bound can be exceeded.
  function automatic logic [COORD_W-1:0] sat_coord(logic [COORD_W-1:0] origin,
                                                   logic [PROD_W-1:0] offset);
    logic signed [SUM_W-1:0] sum;
    sum = $signed({{(SUM_W-COORD_W){origin[COORD_W-1]}}, origin})
        + $signed({2'b00, offset[SUM_W-3:0]});
    if (sum > $signed(SUM_W'(32'h7FFF_FFFF))) begin
      return 32'h7FFF_FFFF;
    end
    return sum[COORD_W-1:0];
  endfunction

endpackage

### rtl/core/mandelbrot_escape_pixel.sv
// Request to result: the point is formed in the MCR, MCI and INIT states, then each step
// uses the single shared 32x32 multiplier three times (zr*zi, zr^2, zi^2); iteration ends
// at the iteration limit, on escape, or when a part of z passes 8 in magnitude.
// One pixel at a time: the next request is taken only after the last result is in the
// output register, where that result waits while the next request is taken.
// Reset clears the sequencer and output valid and loads the default configuration registers.
module mandelbrot_escape_pixel (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // pixel_row [9:0], pixel_col [19:10], zero fill [23:20]
  input  logic [mep_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_row [9:0], out_col [19:10], escape_count [35:20], pixel_rgb [59:36], zero fill
  output logic [mep_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mep_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mep_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  mep_pkg::state_e state_q, state_d;

  logic [mep_pkg::COORD_W-1:0] origin_real_q, origin_imag_q;
  logic [mep_pkg::STEP_W-1:0]  step_real_q, step_imag_q;
  logic [mep_pkg::LIMIT_W-1:0] iteration_limit_q;
  logic [mep_pkg::ESC_W-1:0]   escape_square_q;

  logic [mep_pkg::IDX_W-1:0]   row_q, row_d, col_q, col_d;
  logic [mep_pkg::PROD_W-1:0]  prod_q, prod_d, rr_q, rr_d, ii_q, ii_d;
  logic [mep_pkg::COORD_W-1:0] cr_q, cr_d, ci_q, ci_d;
  logic [mep_pkg::Z_W-1:0]     zr_q, zr_d, zi_q, zi_d;
  logic                        ri_neg_q, ri_neg_d;
  logic [mep_pkg::LIMIT_W-1:0] k_q, k_d;

  logic                        m_valid_q, m_valid_d;
  logic [mep_pkg::IDX_W-1:0]   out_row_q, out_row_d, out_col_q, out_col_d;
  logic [mep_pkg::LIMIT_W-1:0] out_count_q, out_count_d;
  logic [mep_pkg::RGB_W-1:0]   out_rgb_q, out_rgb_d;

  logic [mep_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [mep_pkg::PROD_W-1:0]  mul_p;
  logic [mep_pkg::Z_W-1:0]     zr_mag, zi_mag;
  logic                        z_big;
  logic [mep_pkg::PROD_W-1:0]  mag_sum, esc_level;
  logic [mep_pkg::ESC_W-1:0]   thr;
  logic                        escaped;
  logic                        at_limit;
  logic                        out_free;
  logic signed [mep_pkg::PROD_W-1:0] diff_s, diff_sh, ri_s, ri_sh;

  // Shared multiplier.
  assign mul_p = mul_a * mul_b;

  assign zr_mag = zr_q[mep_pkg::Z_W-1] ? (~zr_q + mep_pkg::Z_W'(1)) : zr_q;
  assign zi_mag = zi_q[mep_pkg::Z_W-1] ? (~zi_q + mep_pkg::Z_W'(1)) : zi_q;
  assign z_big  = (zr_mag > mep_pkg::Z_BOUND) || (zi_mag > mep_pkg::Z_BOUND);

  assign thr       = (escape_square_q > mep_pkg::ESC_MAX) ? mep_pkg::ESC_MAX
                                                          : escape_square_q;
  assign mag_sum   = rr_q + ii_q;
  assign esc_level = {1'b0, thr, {(2 * mep_pkg::FRAC_BITS){1'b0}}};
  assign escaped   = mag_sum > esc_level;
  assign at_limit  = k_q == iteration_limit_q;
  assign out_free  = !m_valid_q || m_axis_tready;

  assign diff_s  = $signed(rr_q) - $signed(ii_q);
  assign diff_sh = diff_s >>> mep_pkg::FRAC_BITS;
  assign ri_s    = ri_neg_q ? -$signed(prod_q) : $signed(prod_q);
  assign ri_sh   = ri_s >>> (mep_pkg::FRAC_BITS - 1);

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(mep_pkg::OUT_TDATA_W - 2 * mep_pkg::IDX_W - mep_pkg::LIMIT_W
                           - mep_pkg::RGB_W){1'b0}},
                          out_rgb_q, out_count_q, out_col_q, out_row_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mep_pkg::ST_IDLE: if (s_axis_tvalid) state_d = mep_pkg::ST_MCR;
      mep_pkg::ST_MCR:  state_d = mep_pkg::ST_MCI;
      mep_pkg::ST_MCI:  state_d = mep_pkg::ST_INIT;
      mep_pkg::ST_INIT: state_d = mep_pkg::ST_RI;
      mep_pkg::ST_RI: begin
        if (at_limit || escaped) state_d = mep_pkg::ST_FIN;
        else state_d = mep_pkg::ST_UPD;
      end
      mep_pkg::ST_UPD:  state_d = mep_pkg::ST_SQR;
      mep_pkg::ST_SQR: begin
        if (z_big) state_d = mep_pkg::ST_FIN;
        else state_d = mep_pkg::ST_SQI;
      end
      mep_pkg::ST_SQI:  state_d = mep_pkg::ST_RI;
      mep_pkg::ST_FIN:  if (out_free) state_d = mep_pkg::ST_IDLE;
      default:          state_d = mep_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    row_d       = row_q;
    col_d       = col_q;
    prod_d      = prod_q;
    rr_d        = rr_q;
    ii_d        = ii_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    zr_d        = zr_q;
    zi_d        = zi_q;
    ri_neg_d    = ri_neg_q;
    k_d         = k_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;
    out_count_d = out_count_q;
    out_rgb_d   = out_rgb_q;
    unique case (state_q)
      mep_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        row_d = s_axis_tdata[mep_pkg::IDX_W-1:0];
        col_d = s_axis_tdata[2*mep_pkg::IDX_W-1:mep_pkg::IDX_W];
      end
      mep_pkg::ST_MCR: begin
        mul_a  = mep_pkg::MUL_W'(col_q);
        mul_b  = mep_pkg::MUL_W'(step_real_q);
        prod_d = mul_p;
      end
      mep_pkg::ST_MCI: begin
        mul_a  = mep_pkg::MUL_W'(row_q);
        mul_b  = mep_pkg::MUL_W'(step_imag_q);
        prod_d = mul_p;
        cr_d   = mep_pkg::sat_coord(origin_real_q, prod_q);
      end
      mep_pkg::ST_INIT: begin
        ci_d = mep_pkg::sat_coord(origin_imag_q, prod_q);
        zr_d = '0;
        zi_d = '0;
        rr_d = '0;
        ii_d = '0;
        k_d  = '0;
      end
      mep_pkg::ST_RI: begin
        mul_a    = zr_mag[mep_pkg::MUL_W-1:0];
        mul_b    = zi_mag[mep_pkg::MUL_W-1:0];
        prod_d   = mul_p;
        ri_neg_d = zr_q[mep_pkg::Z_W-1] ^ zi_q[mep_pkg::Z_W-1];
      end
      mep_pkg::ST_UPD: begin
        zr_d = diff_sh[mep_pkg::Z_W-1:0]
             + {{(mep_pkg::Z_W-mep_pkg::COORD_W){cr_q[mep_pkg::COORD_W-1]}}, cr_q};
        zi_d = ri_sh[mep_pkg::Z_W-1:0]
             + {{(mep_pkg::Z_W-mep_pkg::COORD_W){ci_q[mep_pkg::COORD_W-1]}}, ci_q};
        k_d  = k_q + mep_pkg::LIMIT_W'(1);
      end
      mep_pkg::ST_SQR: begin
        mul_a = zr_mag[mep_pkg::MUL_W-1:0];
        mul_b = zr_mag[mep_pkg::MUL_W-1:0];
        rr_d  = mul_p;
      end
      mep_pkg::ST_SQI: begin
        mul_a = zi_mag[mep_pkg::MUL_W-1:0];
        mul_b = zi_mag[mep_pkg::MUL_W-1:0];
        ii_d  = mul_p;
      end
      mep_pkg::ST_FIN: begin
        if (out_free) begin
          m_valid_d   = 1'b1;
          out_row_d   = row_q;
          out_col_d   = col_q;
          out_count_d = k_q;
          out_rgb_d   = mep_pkg::PALETTE[k_q[mep_pkg::PAL_IDX_W-1:0]];
        end
      end
      default: begin
        m_valid_d = m_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mep_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    prod_q      <= prod_d;
    rr_q        <= rr_d;
    ii_q        <= ii_d;
    cr_q        <= cr_d;
    ci_q        <= ci_d;
    zr_q        <= zr_d;
    zi_q        <= zi_d;
    ri_neg_q    <= ri_neg_d;
    out_row_q   <= out_row_d;
    out_col_q   <= out_col_d;
    out_count_q <= out_count_d;
    out_rgb_q   <= out_rgb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_real_q     <= mep_pkg::ORIGIN_REAL_RST;
      step_real_q       <= mep_pkg::STEP_REAL_RST;
      origin_imag_q     <= mep_pkg::ORIGIN_IMAG_RST;
      step_imag_q       <= mep_pkg::STEP_IMAG_RST;
      iteration_limit_q <= mep_pkg::LIMIT_RST;
      escape_square_q   <= mep_pkg::ESC_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mep_pkg::REG_ORIGIN_REAL: origin_real_q <= cfg_data_i;
        mep_pkg::REG_STEP_REAL:   step_real_q <= cfg_data_i[mep_pkg::STEP_W-1:0];
        mep_pkg::REG_ORIGIN_IMAG: origin_imag_q <= cfg_data_i;
        mep_pkg::REG_STEP_IMAG:   step_imag_q <= cfg_data_i[mep_pkg::STEP_W-1:0];
        mep_pkg::REG_ITER_LIMIT:  iteration_limit_q <= cfg_data_i[mep_pkg::LIMIT_W-1:0];
        mep_pkg::REG_ESC_SQUARE:  escape_square_q <= cfg_data_i[mep_pkg::ESC_W-1:0];
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == mep_pkg::ST_MCR)
    else $error("accepted request did not start the point setup");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == mep_pkg::ST_FIN)
    else $error("result appeared outside the finish state");

  a_square_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mep_pkg::ST_SQI |-> zr_mag <= mep_pkg::Z_BOUND && zi_mag <= mep_pkg::Z_BOUND)
    else $error("multiplier operand exceeds 32 bits");
`endif

endmodule
